// ===== design/mas_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the moving-average smoother.
// Used by the front, queue, back and core modules; depends on nothing.
package mas_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;

  // Must be a power of two so that the queue pointers wrap on their own.
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_SUM
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/mas_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module mas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/mas_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, updates the ring history and the running sum,
// and hands each new sum to the queue. Uses mas_pkg and mas_ram.
module mas_front #(
  parameter int MAX_WINDOW = mas_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF,
  localparam int POS_W = $clog2(MAX_WINDOW),
  localparam int LEN_W = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clr,
  input  logic [LEN_W-1:0]              len,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  mas_pkg::q_status_t            q_status,
  output logic                          push,
  output logic [SUM_W-1:0]              push_sum
);

  mas_pkg::front_state_t state, state_next;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [MAX_WINDOW-1:0] written;
  logic rd_en;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [SAMPLE_BITS-1:0] old;

  mas_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_history (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(pos),
    .wr_data(sample),
    .rd_en  (rd_en),
    .rd_addr(pos),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    rd_en = 1'b0;
    push = 1'b0;
    unique case (state)
      mas_pkg::F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = mas_pkg::F_READ;
        end
      end
      mas_pkg::F_READ: begin
        rd_en = 1'b1;
        state_next = mas_pkg::F_SUM;
      end
      mas_pkg::F_SUM: begin
        if (!q_status.full) begin
          push = 1'b1;
          state_next = mas_pkg::F_IDLE;
        end
      end
      default: begin
        state_next = mas_pkg::F_IDLE;
      end
    endcase
  end

  // Entries never written since the last clear read as zero.
  assign old = written[pos] ? rd_data : '0;
  assign sum_next = sum + SUM_W'(sample) - SUM_W'($signed(old));
  assign pos_next = (LEN_W'(pos) + LEN_W'(1) == len) ? '0 : pos + POS_W'(1);
  assign push_sum = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mas_pkg::F_IDLE;
      pos <= '0;
      sum <= '0;
      written <= '0;
    end else begin
      state <= state_next;
      if (clr) begin
        pos <= '0;
        sum <= '0;
        written <= '0;
      end else if (push) begin
        pos <= pos_next;
        sum <= sum_next;
        written[pos] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mas_pkg::F_IDLE && in_valid) begin
      sample <= sample_in;
    end
  end

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(pos) < len)
    else $error("write position outside the active window");

endmodule

// ===== design/mas_queue.sv =====
`timescale 1ns / 1ps
// Short queue of running sums between the front and back ends.
// Uses mas_pkg for its depth and status type.
module mas_queue #(
  parameter int WIDTH = 22
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output mas_pkg::q_status_t status
);

  localparam int PTR_W = (mas_pkg::Q_DEPTH > 1) ? $clog2(mas_pkg::Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(mas_pkg::Q_DEPTH + 1);

  logic [WIDTH-1:0] entries [mas_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full = (count == CNT_W'(mas_pkg::Q_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from an empty queue");

endmodule

// ===== design/mas_back.sv =====
`timescale 1ns / 1ps
// Back end: divides each running sum by the window length one quotient bit
// per cycle and holds the result in the output register. Uses mas_pkg.
module mas_back #(
  parameter int MAX_WINDOW = mas_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF,
  localparam int LEN_W = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LEN_W-1:0]       len,
  input  mas_pkg::q_status_t     q_status,
  output logic                   pop,
  input  logic [SUM_W-1:0]       pop_sum,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SUM_W-1:0]       window_sum,
  output logic [SAMPLE_BITS-1:0] average_out
);

  localparam int CNT_W = $clog2(SUM_W);

  mas_pkg::back_state_t state, state_next;
  logic load;
  logic [SUM_W-1:0] sum_hold;
  logic neg;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] quo;
  logic [SUM_W-1:0] quo_next;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] rem_next;
  logic [LEN_W:0] rem_shift;
  logic ge;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] quo_signed;

  always_comb begin
    state_next = state;
    pop = 1'b0;
    load = 1'b0;
    unique case (state)
      mas_pkg::B_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          state_next = mas_pkg::B_DIV;
        end
      end
      mas_pkg::B_DIV: begin
        if (cnt == CNT_W'(SUM_W - 1)) begin
          state_next = mas_pkg::B_DONE;
        end
      end
      mas_pkg::B_DONE: begin
        if (!out_valid || !out_stall) begin
          load = 1'b1;
          state_next = mas_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = mas_pkg::B_IDLE;
      end
    endcase
  end

  assign mag = pop_sum[SUM_W-1] ? SUM_W'(-pop_sum) : pop_sum;
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign ge = (rem_shift >= {1'b0, len});
  assign rem_next = ge ? LEN_W'(rem_shift - {1'b0, len}) : rem_shift[LEN_W-1:0];
  assign quo_next = {quo[SUM_W-2:0], ge};
  assign quo_signed = neg ? SUM_W'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mas_pkg::B_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sum_hold <= pop_sum;
      neg <= pop_sum[SUM_W-1];
      quo <= mag;
      rem <= '0;
      cnt <= '0;
    end else if (state == mas_pkg::B_DIV) begin
      quo <= quo_next;
      rem <= rem_next;
      cnt <= cnt + CNT_W'(1);
    end
    if (load) begin
      window_sum <= sum_hold;
      average_out <= quo_signed[SAMPLE_BITS-1:0];
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("output register overwritten while a request is pending");

endmodule

// ===== design/moving_average_smoother_core.sv =====
`timescale 1ns / 1ps
// Moving-average smoother: ring-buffer box filter with a bit-serial divider.
// A sample passes the front end's read and sum states, the queue, then the divider's divide and done states.
// Throughput is set by the serial divider, which pops a new sum only when done with the last one.
// A two-entry queue lets the front end take samples while the divider is busy.
// Synchronous reset clears the history, sum and position and sets the window to 16.
// Writing the window length clears the history, sum and position the same way.
module moving_average_smoother_core #(
  parameter int MAX_WINDOW = mas_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEF,
  localparam int LEN_W = $clog2(MAX_WINDOW + 1),
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mas_pkg::CFG_W-1:0]     window_length,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SUM_W-1:0]       window_sum,
  output logic signed [SAMPLE_BITS-1:0] average_out
);

  logic [mas_pkg::CFG_W-1:0] window_reg;
  logic clr;
  logic [LEN_W-1:0] len;
  mas_pkg::q_status_t q_status;
  logic push;
  logic [SUM_W-1:0] push_sum;
  logic pop;
  logic [SUM_W-1:0] pop_sum;
  logic [SUM_W-1:0] sum_out;
  logic [SAMPLE_BITS-1:0] avg_out;

  assign cfg_ready = 1'b1;
  assign clr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_reg <= mas_pkg::CFG_RESET;
    end else if (clr) begin
      window_reg <= window_length;
    end
  end

  // A zero length acts as one; lengths past the store size saturate.
  always_comb begin
    if (window_reg == '0) begin
      len = LEN_W'(1);
    end else if (32'(window_reg) > 32'(MAX_WINDOW)) begin
      len = LEN_W'(MAX_WINDOW);
    end else begin
      len = LEN_W'(window_reg);
    end
  end

  mas_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .clr      (clr),
    .len      (len),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample_in(sample_in),
    .q_status (q_status),
    .push     (push),
    .push_sum (push_sum)
  );

  mas_queue #(
    .WIDTH(SUM_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_sum),
    .pop      (pop),
    .pop_data (pop_sum),
    .status   (q_status)
  );

  mas_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .len        (len),
    .q_status   (q_status),
    .pop        (pop),
    .pop_sum    (pop_sum),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_sum (sum_out),
    .average_out(avg_out)
  );

  assign window_sum = $signed(sum_out);
  assign average_out = $signed(avg_out);

endmodule

// ===== sim/moving_average_smoother_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for moving_average_smoother_core: random and directed samples
// over several window lengths, with a built-in box-filter predictor. Depends on mas_pkg.
module moving_average_smoother_core_tb;

  localparam int MAX_WINDOW_DEF = mas_pkg::MAX_WINDOW_DEF;
  localparam int CFG_W = mas_pkg::CFG_W;
  localparam logic [CFG_W-1:0] CFG_RESET = mas_pkg::CFG_RESET;
  localparam int SAMPLE_W = mas_pkg::SAMPLE_BITS_DEF;
  localparam int SUM_W = mas_pkg::SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF);
  localparam int LATENCY = SUM_W + 4;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct {
    logic signed [SUM_W-1:0] sum;
    sample_t avg;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] window_length = CFG_RESET;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t sample_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SUM_W-1:0] window_sum;
  sample_t average_out;

  sample_t pending_samples[$];
  smooth_result_t expected_results[$];
  int error_count = 0;
  int hold_left = 0;
  logic no_idle = 1'b0;

  sample_t hist_mem [MAX_WINDOW_DEF];
  int unsigned wr_pos;
  logic signed [SUM_W-1:0] run_sum;
  logic [CFG_W-1:0] win_len;

  moving_average_smoother_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .window_sum   (window_sum),
    .average_out  (average_out)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    error_count++;
  endtask

  task automatic clear_window();
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_pos = 0;
    run_sum = '0;
  endtask

  task automatic advance_window(input sample_t s);
    int unsigned n;
    int unsigned p;
    int sum_i;
    int len_i;
    smooth_result_t r;
    n = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : win_len);
    p = (wr_pos >= n) ? 0 : wr_pos;
    run_sum = run_sum + s - hist_mem[p];
    hist_mem[p] = s;
    p = p + 1;
    wr_pos = (p >= n) ? 0 : p;
    sum_i = run_sum;
    len_i = n;
    r.sum = run_sum;
    r.avg = sample_t'(sum_i / len_i);
    expected_results.push_back(r);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(9))
      0: return sample_t'(16'sh7fff);
      1: return sample_t'(16'sh8000);
      2: return sample_t'($signed($urandom_range(16)) - 8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  always @(posedge clk) begin : sample_driver
    if (rst) begin
      in_valid <= 1'b0;
      sample_in <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_window(sample_in);
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          sample_in <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : hold_counter
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : result_monitor
    smooth_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result request: sum %0d avg %0d",
                                    window_sum, average_out));
        end else begin
          want = expected_results.pop_front();
          if (window_sum !== want.sum) begin
            report_mismatch($sformatf("window_sum %0d, expected %0d", window_sum, want.sum));
          end
          if (average_out !== want.avg) begin
            report_mismatch($sformatf("average_out %0d, expected %0d", average_out, want.avg));
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] len);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    window_length <= len;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    win_len = len;
    clear_window();
  endtask

  task automatic queue_random(input int count);
    repeat (count) pending_samples.push_back(random_sample());
  endtask

  initial begin : stimulus
    win_len = CFG_RESET;
    clear_window();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    pending_samples.push_back(sample_t'(16'sh7fff));
    pending_samples.push_back(sample_t'(16'sh8000));
    pending_samples.push_back(sample_t'(0));
    pending_samples.push_back(sample_t'(-1));
    pending_samples.push_back(sample_t'(1));
    pending_samples.push_back(sample_t'(16'sh5555));
    pending_samples.push_back(sample_t'(16'shaaaa));
    repeat (16) pending_samples.push_back(sample_t'(16'sh8000));

    write_window(7'd1);
    queue_random(120);

    write_window(7'd64);
    hold_left <= HOLD_CYCLES;
    repeat (70) pending_samples.push_back(sample_t'(16'sh8000));
    repeat (70) pending_samples.push_back(sample_t'(16'sh7fff));
    queue_random(60);

    write_window(7'd0);
    queue_random(100);

    write_window(7'd127);
    queue_random(100);

    write_window(7'd65);
    queue_random(100);

    write_window(7'd2);
    no_idle = 1'b1;
    queue_random(150);
    wait_drained();
    no_idle = 1'b0;

    write_window(CFG_RESET);
    queue_random(120);

    repeat (6) begin
      write_window(CFG_W'($urandom_range(1, MAX_WINDOW_DEF)));
      queue_random(80);
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : run_limit
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
